>>> hdl/md5bc_pkg.sv
// ============================================================================
// md5bc_pkg
// Shared types, constants, round tables and microcode for the MD5 block
// compression core.
// ============================================================================
`default_nettype none

package md5bc_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned NumWords  = 16;
  localparam int unsigned NumRounds = 64;
  localparam int unsigned IdxW      = $clog2(NumWords);
  localparam int unsigned RndW      = $clog2(NumRounds);
  localparam int unsigned PcW       = 3;

  typedef logic [WordW-1:0] word_t;
  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [RndW-1:0]  rnd_t;
  typedef logic [PcW-1:0]   pc_t;

  // Standard MD5 initial chaining value, word A at index 0
  localparam word_t IvA = 32'h67452301;
  localparam word_t IvB = 32'hefcdab89;
  localparam word_t IvC = 32'h98badcfe;
  localparam word_t IvD = 32'h10325476;
  localparam logic [3:0][WordW-1:0] Iv = {IvD, IvC, IvB, IvA};

  localparam rnd_t LastRnd = rnd_t'(NumRounds - 1);

  // Datapath operation selected by a microcode step
  typedef enum logic [2:0] {
    OP_WAIT,      // collect message words
    OP_LOAD,      // working regs from chaining value, prefetch first operand
    OP_ROUND,     // one MD5 round
    OP_ADD,       // fold working regs into chaining value
    OP_NOP,       // hold
    OP_EMIT       // present result, release the block buffer
  } op_e;

  // Jump condition; when it holds the sequencer goes to the step's target
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_FULL,
    C_ROUND_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } ucode_t;

  localparam pc_t PcWait    = pc_t'(0);
  localparam pc_t PcLoad    = pc_t'(1);
  localparam pc_t PcRound   = pc_t'(2);
  localparam pc_t PcAdd     = pc_t'(3);
  localparam pc_t PcWaitOut = pc_t'(4);
  localparam pc_t PcEmit    = pc_t'(5);

  // Control store
  function automatic ucode_t ucode(input pc_t pc);
    ucode_t w;
    unique case (pc)
      PcWait:    w = '{op: OP_WAIT,  cond: C_NOT_FULL,   target: PcWait};
      PcLoad:    w = '{op: OP_LOAD,  cond: C_NEVER,      target: PcWait};
      PcRound:   w = '{op: OP_ROUND, cond: C_ROUND_MORE, target: PcRound};
      PcAdd:     w = '{op: OP_ADD,   cond: C_NEVER,      target: PcWait};
      PcWaitOut: w = '{op: OP_NOP,   cond: C_OUT_BUSY,   target: PcWaitOut};
      PcEmit:    w = '{op: OP_EMIT,  cond: C_ALWAYS,     target: PcWait};
      default:   w = '{op: OP_NOP,   cond: C_ALWAYS,     target: PcWait};
    endcase
    return w;
  endfunction

  // Message word used by a round
  function automatic idx_t msg_idx(input rnd_t rnd);
    idx_t r4;
    idx_t i;
    r4 = rnd[IdxW-1:0];
    unique case (rnd[RndW-1 -: 2])
      2'd0:    i = r4;
      2'd1:    i = idx_t'(r4 * idx_t'(5) + idx_t'(1));
      2'd2:    i = idx_t'(r4 * idx_t'(3) + idx_t'(5));
      default: i = idx_t'(r4 * idx_t'(7));
    endcase
    return i;
  endfunction

  // Left rotation per round, four per group
  function automatic logic [4:0] rot_amt(input rnd_t rnd);
    logic [4:0] s;
    unique case ({rnd[RndW-1 -: 2], rnd[1:0]})
      4'd0:  s = 5'd7;
      4'd1:  s = 5'd12;
      4'd2:  s = 5'd17;
      4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;
      4'd5:  s = 5'd9;
      4'd6:  s = 5'd14;
      4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;
      4'd9:  s = 5'd11;
      4'd10: s = 5'd16;
      4'd11: s = 5'd23;
      4'd12: s = 5'd6;
      4'd13: s = 5'd10;
      4'd14: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Additive sine constants
  function automatic word_t round_k(input rnd_t rnd);
    word_t k;
    unique case (rnd)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

>>> hdl/md5bc_msg_if.sv
// ============================================================================
// md5bc_msg_if
// Message word channel: one 32-bit little-endian word per beat.
// ============================================================================
`default_nettype none

interface md5bc_msg_if;
  import md5bc_pkg::*;

  logic  valid;
  logic  ready;
  word_t msg_word;
  logic  start_message;

  modport source (output valid, msg_word, start_message, input ready);
  modport sink   (input valid, msg_word, start_message, output ready);
endinterface

`default_nettype wire

>>> hdl/md5bc_hash_if.sv
// ============================================================================
// md5bc_hash_if
// Chaining value channel: the four chaining words after one block per beat.
// ============================================================================
`default_nettype none

interface md5bc_hash_if;
  import md5bc_pkg::*;

  logic  valid;
  logic  ready;
  word_t hash_a;
  word_t hash_b;
  word_t hash_c;
  word_t hash_d;

  modport source (output valid, hash_a, hash_b, hash_c, hash_d, input ready);
  modport sink   (input valid, hash_a, hash_b, hash_c, hash_d, output ready);
endinterface

`default_nettype wire

>>> hdl/md5bc_round.sv
// ============================================================================
// md5bc_round
// One MD5 round: boolean function, add of the prefetched word plus constant,
// rotation and the final add of B.
// ============================================================================
`default_nettype none

module md5bc_round (
  input  md5bc_pkg::rnd_t  rnd_i,
  input  md5bc_pkg::word_t a_i,
  input  md5bc_pkg::word_t b_i,
  input  md5bc_pkg::word_t c_i,
  input  md5bc_pkg::word_t d_i,
  input  md5bc_pkg::word_t mk_i,    // message word + sine constant
  output md5bc_pkg::word_t b_next_o
);
  import md5bc_pkg::*;

  word_t             f;
  word_t             t;
  logic [4:0]        s;
  logic [2*WordW-1:0] dbl;

  // F, G, H, I by round group
  always_comb begin
    unique case (rnd_i[RndW-1 -: 2])
      2'd0:    f = (b_i & c_i) | (~b_i & d_i);
      2'd1:    f = (b_i & d_i) | (c_i & ~d_i);
      2'd2:    f = b_i ^ c_i ^ d_i;
      default: f = c_i ^ (b_i | ~d_i);
    endcase
  end

  // rotate left, amount is never zero
  assign t        = a_i + f + mk_i;
  assign s        = rot_amt(rnd_i);
  assign dbl      = {t, t} << s;
  assign b_next_o = b_i + dbl[2*WordW-1 -: WordW];

endmodule

`default_nettype wire

>>> hdl/md5_block_compression.sv
// ============================================================================
// md5_block_compression
// MD5 compression core driven by a small microcoded sequencer.
// ============================================================================
// Usage
//   msg_i  : one padded message word per beat, first byte in bits 7:0.
//            start_message on a beat reloads the initial chaining value and
//            makes that word word 0 of a new block (buffered words dropped).
//   hash_o : after every sixteenth word, one beat carrying chaining words
//            A..D after that block.
//   Words are taken one per cycle until the block buffer is full; ready then
//   drops while one shared round unit runs the 64 rounds, one round per
//   cycle. The result becomes valid after the sixteenth word's beat when the
//   steps (full check, one load step, 64 rounds, add, output check, emit)
//   have run, and ready returns in the same cycle.
//   The result sits in an output register: a stalled receiver does not stop
//   the next block's words from being taken; only the emit step of the
//   following block waits until the previous result has gone.
//   Reset loads the initial chaining value, clears the word count and leaves
//   the block buffer contents undefined; no clearing pass is needed.
// ============================================================================
`default_nettype none

module md5_block_compression (
  input  logic                clk_i,
  input  logic                rst_ni,
  md5bc_msg_if.sink           msg_i,
  md5bc_hash_if.source        hash_o
);
  import md5bc_pkg::*;

  // sequencer
  pc_t    pc_q, pc_d;
  ucode_t uw;
  logic   jump;

  // buffer and chaining state
  word_t  blk_q [NumWords];
  idx_t   cnt_q;
  logic   full_q;
  word_t  cv_q [4];

  // working registers
  rnd_t   rnd_q;
  word_t  a_q, b_q, c_q, d_q;
  word_t  mk_q, mk_d;
  word_t  b_next;
  rnd_t   rnd_nx;

  // output register
  logic   out_vld_q;
  word_t  out_q [4];

  logic   in_acc;
  logic   out_busy;

  assign uw       = ucode(pc_q);
  assign in_acc   = msg_i.valid && msg_i.ready;
  assign out_busy = out_vld_q && !hash_o.ready;

  // Jump decode
  always_comb begin
    unique case (uw.cond)
      C_NEVER:      jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_NOT_FULL:   jump = !full_q;
      C_ROUND_MORE: jump = (rnd_q != LastRnd);
      C_OUT_BUSY:   jump = out_busy;
      default:      jump = 1'b1;
    endcase
  end

  assign pc_d = jump ? uw.target : pc_t'(pc_q + pc_t'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcWait;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign msg_i.ready = (uw.op == OP_WAIT) && !full_q;

  // Block buffer write, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      blk_q[msg_i.start_message ? idx_t'(0) : cnt_q] <= msg_i.msg_word;
    end
  end

  // Word count and full flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      full_q <= 1'b0;
    end else if (in_acc) begin
      if (msg_i.start_message) begin
        cnt_q <= idx_t'(1);
      end else begin
        cnt_q  <= idx_t'(cnt_q + idx_t'(1));
        full_q <= (cnt_q == idx_t'(NumWords - 1));
      end
    end else if (uw.op == OP_EMIT) begin
      full_q <= 1'b0;
    end
  end

  // Chaining value: reload on start, accumulate after the rounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) cv_q[i] <= Iv[i];
    end else if (in_acc && msg_i.start_message) begin
      for (int i = 0; i < 4; i++) cv_q[i] <= Iv[i];
    end else if (uw.op == OP_ADD) begin
      cv_q[0] <= cv_q[0] + a_q;
      cv_q[1] <= cv_q[1] + b_q;
      cv_q[2] <= cv_q[2] + c_q;
      cv_q[3] <= cv_q[3] + d_q;
    end
  end

  // Round unit
  md5bc_round u_round (
    .rnd_i    (rnd_q),
    .a_i      (a_q),
    .b_i      (b_q),
    .c_i      (c_q),
    .d_i      (d_q),
    .mk_i     (mk_q),
    .b_next_o (b_next)
  );

  // Operand prefetch for the round after the current one
  assign rnd_nx = (uw.op == OP_ROUND) ? rnd_t'(rnd_q + rnd_t'(1)) : rnd_q;
  assign mk_d   = blk_q[msg_idx(rnd_nx)] + round_k(rnd_nx);

  // Round counter wraps to zero after the last round
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q <= '0;
    end else if (uw.op == OP_ROUND) begin
      rnd_q <= rnd_nx;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (uw.op == OP_LOAD) begin
      a_q  <= cv_q[0];
      b_q  <= cv_q[1];
      c_q  <= cv_q[2];
      d_q  <= cv_q[3];
      mk_q <= mk_d;
    end else if (uw.op == OP_ROUND) begin
      a_q  <= d_q;
      d_q  <= c_q;
      c_q  <= b_q;
      b_q  <= b_next;
      mk_q <= mk_d;
    end
  end

  // Output register; emit only runs when it is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (uw.op == OP_EMIT) begin
      out_vld_q <= 1'b1;
    end else if (hash_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uw.op == OP_EMIT) begin
      for (int i = 0; i < 4; i++) out_q[i] <= cv_q[i];
    end
  end

  assign hash_o.valid  = out_vld_q;
  assign hash_o.hash_a = out_q[0];
  assign hash_o.hash_b = out_q[1];
  assign hash_o.hash_c = out_q[2];
  assign hash_o.hash_d = out_q[3];

endmodule

`default_nettype wire

>>> hdl/md5bc_checker.sv
// ============================================================================
// md5bc_checker
// Port-level checks on the MD5 compression core, bound to the top level.
// ============================================================================
`default_nettype none

module md5bc_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input md5bc_pkg::word_t hash_a_i,
  input md5bc_pkg::word_t hash_b_i,
  input md5bc_pkg::word_t hash_c_i,
  input md5bc_pkg::word_t hash_d_i
);
  import md5bc_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(hash_a_i) &&
      $stable(hash_b_i) && $stable(hash_c_i) && $stable(hash_d_i))
    else $error("result beat changed while stalled");

  // a result appears only at the end of a compression, never while words flow
  a_out_after_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result raised while the word channel was open");

  // no result straight after a word beat
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result raised right after a word beat");

  // the word channel closes only after taking a word
  a_close_on_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i))
    else $error("word channel closed without a beat");

endmodule

bind md5_block_compression md5bc_checker u_md5bc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (msg_i.valid),
  .in_ready_i  (msg_i.ready),
  .out_valid_i (hash_o.valid),
  .out_ready_i (hash_o.ready),
  .hash_a_i    (hash_o.hash_a),
  .hash_b_i    (hash_o.hash_b),
  .hash_c_i    (hash_o.hash_c),
  .hash_d_i    (hash_o.hash_d)
);

`default_nettype wire
